>>> design/brpd_pkg.sv
package brpd_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int MAX_WIDTH_DEF       = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int IMG_W_W    = 13;
  localparam int COL_OUT_W  = 12;
  localparam int ROW_CNT_W  = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RGB16_IS_565  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WITH_COLORS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTICOLOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITISH_CHAN  = 3'd5;

  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_IMAGE   = 1'b1;

  localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX = 15'h7FFF;
  localparam logic [7:0] CHAN_MID  = 8'h80;
  localparam logic [7:0] CHAN_HIGH = 8'hF0;
  localparam logic [9:0] SUM_MID   = 10'd384;

  typedef enum logic [2:0] {
    DEPTH_1  = 3'd0,
    DEPTH_2  = 3'd1,
    DEPTH_4  = 3'd2,
    DEPTH_8  = 3'd3,
    DEPTH_16 = 3'd4,
    DEPTH_24 = 3'd5,
    DEPTH_32 = 3'd6
  } depth_t;

  typedef enum logic [1:0] {
    KIND_RGB565  = 2'd0,
    KIND_WHITE   = 2'd1,
    KIND_BLACK   = 2'd2,
    KIND_COLORED = 2'd3
  } kind_t;

  typedef struct packed {
    logic row_end;
    logic last;
    logic use_pal;
    logic oob;
  } pix_flags_t;

endpackage

>>> design/bmp_row_pixel_decoder.sv
// channel  | ports                          | moves per transaction
// in       | in_valid / in_ready            | palette write or one pixel-data byte
// out      | out_valid / out_ready          | one decoded pixel
// cfg      | cfg_we, cfg_index, cfg_wdata   | one register write, no wait
// a data byte yields up to 8 pixels at 1-bit depth; the unpack stage issues one
// palette read per cycle while the read stage is free, and holds the byte until done
// from unpack to out_valid a pixel passes the palette read register, then classify
// rst_n clears counters, valid flags and config; palette contents are not reset
// a stalled out channel holds the pipeline; a new input is taken as the unpack
// stage finishes its current item
module bmp_row_pixel_decoder #(
  parameter int PALETTE_ENTRIES = brpd_pkg::PALETTE_ENTRIES_DEF,
  parameter int MAX_WIDTH       = brpd_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [brpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [7:0]                     in_palette_index,
  input  logic [23:0]                    in_palette_color,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [brpd_pkg::COL_OUT_W-1:0]  out_column,
  output logic [1:0]                     out_pixel_kind,
  output logic [15:0]                    out_rgb565,
  output logic                           out_row_end,
  output logic                           out_last_of_run
);
  import brpd_pkg::*;

  localparam int AW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RSW  = WW + 6;
  localparam int CMPW = (RSW > ROW_CNT_W) ? RSW : ROW_CNT_W;

  // config
  depth_t               depth_r;
  logic                 is565_r;
  logic [IMG_W_W-1:0]   img_w_r;
  logic                 colors_r;
  logic                 multi_r;
  logic                 whchan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= DEPTH_1;
      is565_r  <= 1'b0;
      img_w_r  <= IMG_W_W'(1);
      colors_r <= 1'b1;
      multi_r  <= 1'b0;
      whchan_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEPTH_CODE:   depth_r  <= depth_t'(cfg_wdata[2:0]);
        CFG_RGB16_IS_565: is565_r  <= cfg_wdata[0];
        CFG_IMAGE_WIDTH:  img_w_r  <= cfg_wdata[IMG_W_W-1:0];
        CFG_WITH_COLORS:  colors_r <= cfg_wdata[0];
        CFG_MULTICOLOR:   multi_r  <= cfg_wdata[0];
        CFG_WHITISH_CHAN: whchan_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective width and row size
  logic [WW-1:0]  w_eff;
  logic [RSW-1:0] w_ext, row_bits, row_bytes, row_size;

  always_comb begin
    if (img_w_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(img_w_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(img_w_r);
    end
    w_ext = RSW'(w_eff);
    case (depth_r)
      DEPTH_1:  row_bits = w_ext;
      DEPTH_2:  row_bits = w_ext << 1;
      DEPTH_4:  row_bits = w_ext << 2;
      DEPTH_8:  row_bits = w_ext << 3;
      DEPTH_16: row_bits = w_ext << 4;
      DEPTH_24: row_bits = (w_ext << 4) + (w_ext << 3);
      default:  row_bits = w_ext << 5;
    endcase
    row_bytes = (row_bits + RSW'(7)) >> 3;
    row_size  = (row_bytes + RSW'(3)) & ~RSW'(3);
  end

  // input register
  logic        u_valid_r;
  logic        u_type_r;
  logic [7:0]  u_byte_r;
  logic [7:0]  u_pidx_r;
  logic [23:0] u_pcolor_r;

  // row state
  logic [WW-1:0]        col_r, col_nxt;
  logic [ROW_CNT_W-1:0] rb_r, rb_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [23:0]          part_r, part_nxt;

  // read and classify stages
  logic          p_valid_r;
  logic [WW-1:0] p_col_r;
  pix_flags_t    p_flags_r;
  logic [23:0]   p_direct_r;
  logic [23:0]   pal_q_r;

  logic                 out_valid_r;
  logic [COL_OUT_W-1:0] out_col_r;
  kind_t                out_kind_r;
  logic [15:0]          out_rgb_r;
  logic                 out_row_end_r;
  logic                 out_last_r;

  logic o_free, p_free;
  assign o_free = !out_valid_r || out_ready;
  assign p_free = !p_valid_r || o_free;

  // unpack step
  logic          u_done, u_emit, pal_we, pos_last;
  logic [7:0]    pix_idx, sh_byte;
  logic [23:0]   part_new, direct;
  logic [2:0]    ph_inc, bpp;
  pix_flags_t    emit_flags;
  logic [CMPW-1:0] rb_cmp, rs_cmp;

  always_comb begin
    u_done     = 1'b0;
    u_emit     = 1'b0;
    pal_we     = 1'b0;
    pos_last   = 1'b1;
    pix_idx    = '0;
    sh_byte    = '0;
    part_new   = part_r;
    direct     = '0;
    ph_inc     = {1'b0, phase_r} + 3'd1;
    bpp        = 3'd4;
    emit_flags = '0;
    col_nxt    = col_r;
    rb_nxt     = rb_r;
    phase_nxt  = phase_r;
    part_nxt   = part_r;
    rb_cmp     = '0;
    rs_cmp     = '0;
    if (u_valid_r) begin
      if (u_type_r == REQ_PALETTE) begin
        pal_we = (int'(u_pidx_r) < PALETTE_ENTRIES);
        u_done = 1'b1;
      end else if (p_free) begin
        u_done = 1'b1;
        if (col_r < w_eff) begin
          col_nxt = col_r + WW'(1);
          u_emit  = 1'b1;
          case (depth_r)
            DEPTH_1: begin
              pix_idx  = {7'd0, u_byte_r[3'd7 - col_r[2:0]]};
              pos_last = (col_r[2:0] == 3'd7);
            end
            DEPTH_2: begin
              sh_byte  = u_byte_r >> (3'd6 - {col_r[1:0], 1'b0});
              pix_idx  = {6'd0, sh_byte[1:0]};
              pos_last = (col_r[1:0] == 2'd3);
            end
            DEPTH_4: begin
              pix_idx  = col_r[0] ? {4'd0, u_byte_r[3:0]} : {4'd0, u_byte_r[7:4]};
              pos_last = col_r[0];
            end
            DEPTH_8: begin
              pix_idx = u_byte_r;
            end
            default: begin
              case (depth_r)
                DEPTH_16: bpp = 3'd2;
                DEPTH_24: bpp = 3'd3;
                default:  bpp = 3'd4;
              endcase
              case (phase_r)
                2'd0:    part_new[7:0]   = u_byte_r;
                2'd1:    part_new[15:8]  = u_byte_r;
                2'd2:    part_new[23:16] = u_byte_r;
                default: ;
              endcase
              if (depth_r == DEPTH_16) begin
                if (is565_r) begin
                  direct = {part_new[15:11], 3'd0, part_new[10:8], part_new[7:5], 2'd0,
                            part_new[4:0], 3'd0};
                end else begin
                  direct = {part_new[14:10], 3'd0, part_new[9:8], part_new[7:5], 3'd0,
                            part_new[4:0], 3'd0};
                end
              end else begin
                direct = part_new;
              end
              if (ph_inc >= bpp) begin
                phase_nxt = 2'd0;
                part_nxt  = '0;
              end else begin
                u_emit    = 1'b0;
                col_nxt   = col_r;
                phase_nxt = ph_inc[1:0];
                part_nxt  = part_new;
              end
            end
          endcase
          if (depth_r == DEPTH_1 || depth_r == DEPTH_2 || depth_r == DEPTH_4 ||
              depth_r == DEPTH_8) begin
            u_done = pos_last || (col_nxt >= w_eff);
            emit_flags.use_pal = 1'b1;
            emit_flags.oob     = (int'(pix_idx) >= PALETTE_ENTRIES);
          end
          emit_flags.row_end = (col_nxt == w_eff);
          emit_flags.last    = u_done;
        end
        if (u_done) begin
          if (rb_r < ROW_CNT_MAX) begin
            rb_nxt = rb_r + ROW_CNT_W'(1);
          end
          rb_cmp = CMPW'(rb_nxt);
          rs_cmp = CMPW'(row_size);
          if (col_nxt >= w_eff && rb_cmp >= rs_cmp) begin
            col_nxt   = '0;
            rb_nxt    = '0;
            phase_nxt = 2'd0;
            part_nxt  = '0;
          end
        end
      end
    end
  end

  assign in_ready = !u_valid_r || u_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_valid_r <= 1'b0;
      col_r     <= '0;
      rb_r      <= '0;
      phase_r   <= 2'd0;
      part_r    <= '0;
    end else begin
      if (in_valid && in_ready) begin
        u_valid_r <= 1'b1;
      end else if (u_done) begin
        u_valid_r <= 1'b0;
      end
      col_r   <= col_nxt;
      rb_r    <= rb_nxt;
      phase_r <= phase_nxt;
      part_r  <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      u_type_r   <= in_req_type;
      u_byte_r   <= in_data_byte;
      u_pidx_r   <= in_palette_index;
      u_pcolor_r <= in_palette_color;
    end
  end

  // palette memory
  logic [23:0] pal_mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[u_pidx_r[AW-1:0]] <= u_pcolor_r;
    end
    if (u_emit && emit_flags.use_pal) begin
      pal_q_r <= pal_mem[pix_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (p_free) begin
      p_valid_r <= u_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (u_emit) begin
      p_col_r    <= col_r;
      p_flags_r  <= emit_flags;
      p_direct_r <= direct;
    end
  end

  // classification
  logic [23:0] color;
  logic [7:0]  ch_r, ch_g, ch_b;
  logic [9:0]  ch_sum;
  logic        colors, white, colored;
  kind_t       kind;
  logic [15:0] rgb;

  always_comb begin
    if (p_flags_r.use_pal) begin
      color = p_flags_r.oob ? 24'd0 : pal_q_r;
    end else begin
      color = p_direct_r;
    end
    ch_r    = color[23:16];
    ch_g    = color[15:8];
    ch_b    = color[7:0];
    ch_sum  = {2'd0, ch_r} + {2'd0, ch_g} + {2'd0, ch_b};
    colors  = colors_r && (depth_r != DEPTH_1);
    if (whchan_r) begin
      white = (ch_r > CHAN_MID) && (ch_g > CHAN_MID) && (ch_b > CHAN_MID);
    end else begin
      white = ch_sum > SUM_MID;
    end
    colored = (ch_r > CHAN_HIGH) || ((ch_g > CHAN_HIGH) && (ch_b > CHAN_HIGH));
    rgb     = '0;
    if (colors && multi_r) begin
      kind = KIND_RGB565;
      rgb  = {ch_r[7:3], ch_g[7:2], ch_b[7:3]};
    end else if (white) begin
      kind = KIND_WHITE;
    end else if (colored && colors) begin
      kind = KIND_COLORED;
    end else begin
      kind = KIND_BLACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_free) begin
      out_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && p_valid_r) begin
      out_col_r     <= COL_OUT_W'(p_col_r);
      out_kind_r    <= kind;
      out_rgb_r     <= rgb;
      out_row_end_r <= p_flags_r.row_end;
      out_last_r    <= p_flags_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_column      = out_col_r;
  assign out_pixel_kind  = out_kind_r;
  assign out_rgb565      = out_rgb_r;
  assign out_row_end     = out_row_end_r;
  assign out_last_of_run = out_last_r;

  // checks
  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    u_emit |-> p_free)
    else $error("pixel issued into a busy read stage");

  a_palette_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    pal_we |-> !u_emit)
    else $error("palette write produced a pixel");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r && !o_free |=> p_valid_r && $stable(p_col_r) && $stable(pal_q_r))
    else $error("read stage changed while stalled");

endmodule

>>> bench/bmp_row_pixel_decoder_tb.sv
`default_nettype none

module bmp_row_pixel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brpd_pkg::*;

  localparam logic [2:0] DEPTH_32_ALT = 3'd7;

  typedef struct {
    logic [11:0] column;
    kind_t kind;
    logic [15:0] rgb;
    logic row_end;
    logic last;
  } pixel_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = REQ_PALETTE;
  logic [7:0] in_palette_index = '0;
  logic [23:0] in_palette_color = '0;
  logic [7:0] in_data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COL_OUT_W-1:0] out_column;
  logic [1:0] out_pixel_kind;
  logic [15:0] out_rgb565;
  logic out_row_end;
  logic out_last_of_run;

  bmp_row_pixel_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_palette_index(in_palette_index),
    .in_palette_color(in_palette_color),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_column(out_column),
    .out_pixel_kind(out_pixel_kind),
    .out_rgb565(out_rgb565),
    .out_row_end(out_row_end),
    .out_last_of_run(out_last_of_run)
  );

  // decoder shadow state
  logic [2:0] depth_code = DEPTH_1;
  logic rgb16_565 = 1'b0;
  logic [12:0] width_reg = 13'd1;
  logic with_colors = 1'b1;
  logic multicolor = 1'b0;
  logic whitish_chan = 1'b0;
  logic [23:0] palette [256];
  bit entry_loaded [256];
  int loaded_entries [$];
  int col_cnt = 0;
  int row_bytes = 0;
  logic [23:0] part_pix = '0;
  int phase = 0;

  pixel_t pixels_due [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_pending = 1'b0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("** bmp_row_pixel_decoder: FAILED **");
    $finish;
  end

  function automatic int pixel_bits(logic [2:0] code);
    case (code)
      DEPTH_1: return 1;
      DEPTH_2: return 2;
      DEPTH_4: return 4;
      DEPTH_8: return 8;
      DEPTH_16: return 16;
      DEPTH_24: return 24;
      default: return 32;
    endcase
  endfunction

  function automatic int row_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(width_reg);
  endfunction

  function automatic logic [23:0] wide_color();
    logic [7:0] b0, b1, r, g, b;
    b0 = part_pix[7:0];
    b1 = part_pix[15:8];
    if (depth_code != DEPTH_16) return part_pix;
    if (rgb16_565) begin
      r = {b1[7:3], 3'b000};
      g = {b1[2:0], b0[7:5], 2'b00};
    end else begin
      r = {b1[6:2], 3'b000};
      g = {b1[1:0], b0[7:5], 3'b000};
    end
    b = {b0[4:0], 3'b000};
    return {r, g, b};
  endfunction

  function automatic pixel_t classify(logic [23:0] rgb, int col, int w);
    pixel_t p;
    logic [7:0] r, g, b;
    bit colors, white, colored;
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    colors = with_colors && (depth_code != DEPTH_1);
    if (whitish_chan) white = (r > CHAN_MID) && (g > CHAN_MID) && (b > CHAN_MID);
    else white = (int'(r) + int'(g) + int'(b)) > int'(SUM_MID);
    colored = (r > CHAN_HIGH) || ((g > CHAN_HIGH) && (b > CHAN_HIGH));
    p.column = 12'(col);
    p.rgb = '0;
    p.row_end = (col + 1 == w);
    p.last = 1'b0;
    if (colors && multicolor) begin
      p.kind = KIND_RGB565;
      p.rgb = {r[7:3], g[7:2], b[7:3]};
    end else if (white) begin
      p.kind = KIND_WHITE;
    end else if (colored && colors) begin
      p.kind = KIND_COLORED;
    end else begin
      p.kind = KIND_BLACK;
    end
    return p;
  endfunction

  function automatic void decode_bmp_item(logic req, logic [7:0] pidx, logic [23:0] pcol,
                                          logic [7:0] data);
    int w, d, rs, ppb, pos, idx, ph;
    pixel_t run [$];
    if (req == REQ_PALETTE) begin
      if (!entry_loaded[pidx]) begin
        entry_loaded[pidx] = 1'b1;
        loaded_entries.push_back(int'(pidx));
      end
      palette[pidx] = pcol;
      return;
    end
    w = row_width();
    d = pixel_bits(depth_code);
    rs = (((w * d + 7) / 8) + 3) & ~3;
    if (col_cnt < w) begin
      if (d <= 8) begin
        ppb = 8 / d;
        pos = col_cnt % ppb;
        while (pos < ppb && col_cnt < w) begin
          idx = (int'(data) >> (8 - d - pos * d)) & ((1 << d) - 1);
          run.push_back(classify(palette[idx], col_cnt, w));
          col_cnt++;
          pos++;
        end
      end else begin
        ph = phase;
        if (ph < 3) part_pix[8 * ph +: 8] = data;
        ph++;
        if (ph >= d / 8) begin
          run.push_back(classify(wide_color(), col_cnt, w));
          col_cnt++;
          ph = 0;
          part_pix = '0;
        end
        phase = ph;
      end
    end
    if (row_bytes < int'(ROW_CNT_MAX)) row_bytes++;
    if (col_cnt >= w && row_bytes >= rs) begin
      col_cnt = 0;
      row_bytes = 0;
      phase = 0;
      part_pix = '0;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) pixels_due.push_back(run[i]);
  endfunction

  function automatic int pick_entry(int limit);
    int e;
    for (int t = 0; t < 16; t++) begin
      e = loaded_entries[$urandom_range(loaded_entries.size() - 1)];
      if (e <= limit) return e;
    end
    return 0;
  endfunction

  // only loaded palette entries may be indexed by a decoded pixel
  function automatic logic [7:0] image_byte();
    int d;
    logic [7:0] b;
    d = pixel_bits(depth_code);
    if (d > 8 || col_cnt >= row_width()) return 8'($urandom);
    b = '0;
    for (int k = 0; k < 8 / d; k++) b = (b << d) | 8'(pick_entry((1 << d) - 1));
    return b;
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(5))
      0: return CHAN_MID;
      1: return CHAN_MID + 8'd1;
      2: return CHAN_HIGH;
      3: return CHAN_HIGH + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] random_color();
    return {pick_channel(), pick_channel(), pick_channel()};
  endfunction

  task automatic send_item(logic req, logic [7:0] pidx, logic [23:0] pcol, logic [7:0] data);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_palette_index <= pidx;
    in_palette_color <= pcol;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    decode_bmp_item(req, pidx, pcol, data);
    items_sent++;
  endtask

  task automatic send_palette(logic [7:0] idx, logic [23:0] color);
    send_item(REQ_PALETTE, idx, color, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] data);
    send_item(REQ_IMAGE, 8'($urandom), 24'($urandom), data);
  endtask

  task automatic send_image();
    send_byte(image_byte());
  endtask

  // broken rows may stop early and leave the counters mid-row
  task automatic send_row(bit broken);
    int cap, cnt;
    cap = broken ? $urandom_range(1, 6) : 700;
    cnt = 0;
    do begin
      if ($urandom_range(9) == 0) send_palette(8'($urandom), random_color());
      send_image();
      cnt++;
    end while (!(col_cnt == 0 && row_bytes == 0) && cnt < cap);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic configure(logic [12:0] depth, logic [12:0] is565, logic [12:0] width,
                           logic [12:0] colors, logic [12:0] multi, logic [12:0] whitish);
    logic [CFG_IDX_W-1:0] regs [6];
    logic [12:0] vals [6];
    regs = '{CFG_DEPTH_CODE, CFG_RGB16_IS_565, CFG_IMAGE_WIDTH, CFG_WITH_COLORS,
             CFG_MULTICOLOR, CFG_WHITISH_CHAN};
    vals = '{depth, is565, width, colors, multi, whitish};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (regs[i])
        CFG_DEPTH_CODE: depth_code = vals[i][2:0];
        CFG_RGB16_IS_565: rgb16_565 = vals[i][0];
        CFG_IMAGE_WIDTH: width_reg = vals[i];
        CFG_WITH_COLORS: with_colors = vals[i][0];
        CFG_MULTICOLOR: multicolor = vals[i][0];
        CFG_WHITISH_CHAN: whitish_chan = vals[i][0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_palette_load();
    send_palette(8'd0, 24'h000000);
    send_palette(8'd1, 24'hFFFFFF);
    send_palette(8'd2, 24'hF81000);
    send_palette(8'd3, 24'h10F1F1);
    send_palette(8'd254, 24'h808081);
    send_palette(8'd255, 24'h818181);
  endtask

  // one bit per pixel forces black and white, multicolor ignored
  task automatic test_mono_rows();
    settle();
    configure(13'(DEPTH_1), 13'd0, 13'd9, 13'd1, 13'd1, 13'd0);
    send_byte(8'hA5);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_indexed_classes();
    settle();
    configure(13'(DEPTH_2), 13'd0, 13'd4, 13'd1, 13'd0, 13'd1);
    send_byte(8'h1B);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h5A);
  endtask

  task automatic test_wide_pixels();
    settle();
    configure(13'(DEPTH_16), 13'd1, 13'd1, 13'd1, 13'd1, 13'd0);
    send_byte(8'hE3);
    send_byte(8'hF8);
    send_byte(8'h00);
    send_byte(8'hFF);
    settle();
    configure(13'(DEPTH_32_ALT), 13'd0, 13'd0, 13'd1, 13'd1, 13'd1);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h9A);
  endtask

  // oversized width clamps, then a zero width drains the row as padding
  task automatic test_width_limits();
    settle();
    configure(13'(DEPTH_1), 13'd0, 13'd8191, 13'd1, 13'd0, 13'd0);
    send_byte(8'h5A);
    settle();
    configure(13'(DEPTH_1), 13'd0, 13'd0, 13'd1, 13'd0, 13'd0);
    repeat (3) send_byte(8'($urandom));
  endtask

  task automatic test_backpressure();
    settle();
    configure(13'(DEPTH_1), 13'd0, 13'd16, 13'd1, 13'd1, 13'd0);
    hold_pending = 1'b1;
    repeat (3) send_row(1'b0);
    settle();
  endtask

  task automatic random_setup(output bit huge);
    logic [12:0] depth, width, junk;
    int pick;
    depth = 13'($urandom_range(7));
    pick = $urandom_range(19);
    huge = 1'b0;
    if (pick == 0) begin
      width = '0;
    end else if (pick == 1) begin
      width = ($urandom_range(1) == 0) ? 13'd4096 : 13'($urandom_range(4097, 8191));
      huge = 1'b1;
    end else begin
      width = 13'((depth < DEPTH_16) ? $urandom_range(1, 40) : $urandom_range(1, 10));
    end
    junk = ($urandom_range(3) == 0) ? (13'($urandom) & 13'h1FF8) : '0;
    configure(depth | junk, 13'($urandom_range(1)) | junk, width,
              13'($urandom_range(3) != 0) | junk, 13'($urandom_range(1)) | junk,
              13'($urandom_range(1)) | junk);
  endtask

  task automatic run_random_phase(int idle_pct, int stall_pct, int item_goal);
    int stop_at;
    bit huge;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + item_goal;
    while (items_sent < stop_at) begin
      settle();
      random_setup(huge);
      if ($urandom_range(3) == 0) send_palette(8'($urandom), random_color());
      if (huge) send_row(1'b1);
      else repeat ($urandom_range(1, 3)) send_row($urandom_range(5) == 0);
    end
  endtask

  task automatic test_random();
    run_random_phase(0, 0, 65);
    run_random_phase(55, 0, 65);
    run_random_phase(0, 55, 65);
    run_random_phase(25, 25, 65);
  endtask

  always @(posedge clk) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string what, int got, int want_v);
    if (got != want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual column %0h",
                 $time, out_column);
        mismatch_count++;
      end else begin
        want = pixels_due.pop_front();
        check_field("column", int'(out_column), int'(want.column));
        check_field("pixel_kind", int'(out_pixel_kind), int'(want.kind));
        check_field("rgb565", int'(out_rgb565), int'(want.rgb));
        check_field("row_end", int'(out_row_end), int'(want.row_end));
        check_field("last_of_run", int'(out_last_of_run), int'(want.last));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_palette_load();
    test_mono_rows();
    test_indexed_classes();
    test_wide_pixels();
    test_width_limits();
    test_backpressure();
    test_random();
    settle();
    if (mismatch_count == 0) $display("** bmp_row_pixel_decoder: PASSED **");
    else $display("** bmp_row_pixel_decoder: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
